[hdl/sdh_pkg.sv]
package sdh_pkg;

	// Default sizing of the block.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_DIST_DEF   = 2;
	localparam int COUNT_BITS_DEF = 21;

	// Fixed field widths and histogram geometry.
	localparam int PIXEL_BITS    = 8;
	localparam int BIN_BITS      = 9;
	localparam int NBINS         = 511;
	localparam int GRAY_MAX      = 255;
	localparam int ACT_BITS      = 2;
	localparam int IMG_W_BITS    = 11;
	localparam int DIST_BITS     = 2;
	localparam int DIR_BITS      = 2;
	localparam int ROW_BITS      = 11;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 11;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET   = 11'd1024;
	localparam logic [DIST_BITS-1:0]  PAIR_DISTANCE_RESET = 2'd1;

	typedef enum logic [ACT_BITS-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic [DIR_BITS-1:0] {
		DIR_0   = 2'd0,
		DIR_45  = 2'd1,
		DIR_90  = 2'd2,
		DIR_135 = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_PAIR_DISTANCE = 2'd1,
		REG_DIRECTION     = 2'd2
	} reg_idx_t;

	// Operations handed from the front end to the histogram engine.
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PAIR  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic [IMG_W_BITS-1:0] image_width;
		logic [DIST_BITS-1:0]  pair_distance;
		dir_t                  direction;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [BIN_BITS-1:0] sum_bin;
		logic [BIN_BITS-1:0] diff_bin;
	} hist_op_t;

endpackage

[hdl/sdh_ram.sv]
module sdh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/sdh_queue.sv]
module sdh_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sdh_pkg::hist_op_t push_data,
	output logic              full,
	input  logic              pop,
	output sdh_pkg::hist_op_t head,
	output logic              empty
);

	localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CB = $clog2(DEPTH + 1);

	sdh_pkg::hist_op_t entry_q [DEPTH];
	logic [PB-1:0] wr_ptr_q;
	logic [PB-1:0] rd_ptr_q;
	logic [CB-1:0] count_q;

	assign full  = (count_q == CB'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(DEPTH - 1)) ? '0 : wr_ptr_q + PB'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(DEPTH - 1)) ? '0 : rd_ptr_q + PB'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CB'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CB'(1);
			end
		end
	end

endmodule

[hdl/sdh_front.sv]
module sdh_front #(
	parameter int MAX_WIDTH = sdh_pkg::MAX_WIDTH_DEF,
	parameter int MAX_DIST  = sdh_pkg::MAX_DIST_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sdh_pkg::cfg_t                   cfg,
	input  logic                            hold,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sdh_pkg::ACT_BITS-1:0]    action,
	input  logic [sdh_pkg::PIXEL_BITS-1:0]  pixel,
	input  logic [sdh_pkg::BIN_BITS-1:0]    bin_index,
	input  logic                            q_full,
	output logic                            q_push,
	output sdh_pkg::hist_op_t               q_entry
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = CW + 1;
	localparam int PW     = CW + 2;
	localparam int EW     = (WW > sdh_pkg::IMG_W_BITS) ? WW : sdh_pkg::IMG_W_BITS;
	localparam int NSLOTS = MAX_DIST + 1;
	localparam int SB     = $clog2(NSLOTS);
	localparam int DEW    = (SB > sdh_pkg::DIST_BITS) ? SB : sdh_pkg::DIST_BITS;
	localparam int US     = DEW + 1;
	localparam int LS_DEPTH = NSLOTS * MAX_WIDTH;
	localparam int LAW    = $clog2(LS_DEPTH);
	localparam int PXB    = sdh_pkg::PIXEL_BITS;
	localparam int BB     = sdh_pkg::BIN_BITS;

	// Position in the image and the line store slot of the current row.
	logic [CW-1:0]                col_q;
	logic [sdh_pkg::ROW_BITS-1:0] row_q;
	logic [SB-1:0]                slot_q;

	// Classified item waiting for its line store read.
	logic            valid_s1;
	sdh_pkg::op_t    op_s1;
	logic [PXB-1:0]  pixel_s1;
	logic            swap_s1;
	logic [BB-1:0]   bin_s1;

	logic [PXB-1:0]  ls_rdata;
	logic [WW-1:0]   w_eff;
	logic [DEW-1:0]  d_eff;
	logic [EW-1:0]   iw_ext;
	logic [PW-1:0]   c_x;
	logic [PW-1:0]   d_x;
	logic [PW-1:0]   w_x;
	logic            c_ge_d;
	logic            c_lt_w;
	logic            row_ge_d;
	logic            pair_ok;
	logic            last_col;
	logic [PW-1:0]   nb_col_x;
	logic [SB-1:0]   nb_slot;
	logic [SB-1:0]   up_slot;
	logic [US-1:0]   cur_u;
	logic [US-1:0]   d_u;
	logic [LAW-1:0]  ls_waddr;
	logic [LAW-1:0]  ls_raddr;
	logic            accept;
	logic            take_pixel;
	logic [PXB-1:0]  cur_px;
	logic [PXB-1:0]  nb_px;
	logic [BB-1:0]   sum_bin;
	logic [BB-1:0]   diff_bin;

	assign in_stall   = hold || (valid_s1 && q_full);
	assign accept     = in_valid && !in_stall;
	assign take_pixel = accept && (sdh_pkg::action_t'(action) == sdh_pkg::ACT_PIXEL);

	always_comb begin
		iw_ext = EW'(cfg.image_width);
		if (iw_ext == '0) begin
			w_eff = WW'(1);
		end else if (iw_ext > EW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(iw_ext);
		end

		d_eff = DEW'(cfg.pair_distance);
		if (d_eff == '0) begin
			d_eff = DEW'(1);
		end else if (int'(d_eff) > MAX_DIST) begin
			d_eff = DEW'(MAX_DIST);
		end

		c_x      = PW'(col_q);
		d_x      = PW'(d_eff);
		w_x      = PW'(w_eff);
		c_ge_d   = (c_x >= d_x);
		c_lt_w   = (c_x < w_x);
		row_ge_d = (row_q >= sdh_pkg::ROW_BITS'(d_eff));
		last_col = ((c_x + PW'(1)) >= w_x);

		cur_u = US'(slot_q);
		d_u   = US'(d_eff);
		if (cur_u >= d_u) begin
			up_slot = SB'(cur_u - d_u);
		end else begin
			up_slot = SB'(cur_u + US'(NSLOTS) - d_u);
		end

		case (cfg.direction)
			sdh_pkg::DIR_0: begin
				pair_ok  = c_ge_d && c_lt_w;
				nb_col_x = c_x - d_x;
				nb_slot  = slot_q;
			end
			sdh_pkg::DIR_45: begin
				pair_ok  = row_ge_d && ((c_x + d_x) < w_x);
				nb_col_x = c_x + d_x;
				nb_slot  = up_slot;
			end
			sdh_pkg::DIR_90: begin
				pair_ok  = row_ge_d && c_lt_w;
				nb_col_x = c_x;
				nb_slot  = up_slot;
			end
			default: begin
				pair_ok  = row_ge_d && c_ge_d && c_lt_w;
				nb_col_x = c_x - d_x;
				nb_slot  = up_slot;
			end
		endcase
		if (!pair_ok) begin
			nb_col_x = c_x;
		end

		ls_waddr = LAW'(LAW'(slot_q) * LAW'(MAX_WIDTH)) + LAW'(col_q);
		ls_raddr = LAW'(LAW'(nb_slot) * LAW'(MAX_WIDTH)) + LAW'(nb_col_x);
	end

	sdh_ram #(
		.WIDTH (PXB),
		.DEPTH (LS_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (take_pixel),
		.waddr (ls_waddr),
		.wdata (pixel),
		.re    (take_pixel),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (q_push) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				case (sdh_pkg::action_t'(action))
					sdh_pkg::ACT_CLEAR: begin
						col_q    <= '0;
						row_q    <= '0;
						slot_q   <= '0;
						valid_s1 <= 1'b1;
					end
					sdh_pkg::ACT_PIXEL: begin
						valid_s1 <= pair_ok;
						if (last_col) begin
							col_q <= '0;
							if (row_q != '1) begin
								row_q <= row_q + sdh_pkg::ROW_BITS'(1);
							end
							slot_q <= (slot_q == SB'(NSLOTS - 1)) ? '0 : slot_q + SB'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
					sdh_pkg::ACT_READ: begin
						valid_s1 <= 1'b1;
					end
					default: begin
						valid_s1 <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (sdh_pkg::action_t'(action))
				sdh_pkg::ACT_CLEAR: op_s1 <= sdh_pkg::OP_CLEAR;
				sdh_pkg::ACT_READ:  op_s1 <= sdh_pkg::OP_READ;
				default:            op_s1 <= sdh_pkg::OP_PAIR;
			endcase
			pixel_s1 <= pixel;
			swap_s1  <= (cfg.direction == sdh_pkg::DIR_0);
			bin_s1   <= bin_index;
		end
	end

	// At 0 degrees the stored pixel is the current one and the new pixel the neighbor.
	always_comb begin
		cur_px   = swap_s1 ? ls_rdata : pixel_s1;
		nb_px    = swap_s1 ? pixel_s1 : ls_rdata;
		sum_bin  = BB'(cur_px) + BB'(nb_px);
		diff_bin = BB'(cur_px) + BB'(sdh_pkg::GRAY_MAX) - BB'(nb_px);

		q_entry.op = op_s1;
		if (op_s1 == sdh_pkg::OP_PAIR) begin
			q_entry.sum_bin  = sum_bin;
			q_entry.diff_bin = diff_bin;
		end else begin
			q_entry.sum_bin  = bin_s1;
			q_entry.diff_bin = bin_s1;
		end
	end

	assign q_push = valid_s1 && !q_full;

endmodule

[hdl/sdh_back.sv]
module sdh_back #(
	parameter int COUNT_BITS = sdh_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  sdh_pkg::hist_op_t     q_head,
	output logic                  q_pop,
	output logic                  busy,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COUNT_BITS-1:0] sum_count,
	output logic [COUNT_BITS-1:0] diff_count
);

	localparam int BB = sdh_pkg::BIN_BITS;

	// Clearing sweep over both histograms; also runs once after reset.
	logic          sweep_q;
	logic [BB-1:0] sweep_addr_q;

	// Operation whose bin reads are in flight.
	logic          valid_s2;
	sdh_pkg::op_t  op_s2;
	logic [BB-1:0] sum_bin_s2;
	logic [BB-1:0] diff_bin_s2;
	logic          oor_s2;

	// Last write of each histogram, for a read issued at the same edge.
	logic                  fwd_s_valid_q;
	logic [BB-1:0]         fwd_s_addr_q;
	logic [COUNT_BITS-1:0] fwd_s_data_q;
	logic                  fwd_d_valid_q;
	logic [BB-1:0]         fwd_d_addr_q;
	logic [COUNT_BITS-1:0] fwd_d_data_q;

	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_sum_q;
	logic [COUNT_BITS-1:0] out_diff_q;

	logic                  can_read;
	logic                  head_oor;
	logic                  rd_en;
	logic [COUNT_BITS-1:0] s_rdata;
	logic [COUNT_BITS-1:0] d_rdata;
	logic [COUNT_BITS-1:0] s_old;
	logic [COUNT_BITS-1:0] d_old;
	logic [COUNT_BITS-1:0] s_new;
	logic [COUNT_BITS-1:0] d_new;
	logic                  wr_en;
	logic [BB-1:0]         s_waddr;
	logic [BB-1:0]         d_waddr;
	logic [COUNT_BITS-1:0] s_wdata;
	logic [COUNT_BITS-1:0] d_wdata;

	assign can_read = !out_valid_q && !(valid_s2 && (op_s2 == sdh_pkg::OP_READ));
	assign q_pop    = !q_empty && !sweep_q &&
	                  ((q_head.op != sdh_pkg::OP_READ) || can_read);
	assign head_oor = (q_head.sum_bin >= BB'(sdh_pkg::NBINS));
	assign rd_en    = q_pop && (q_head.op != sdh_pkg::OP_CLEAR) && !head_oor;
	assign busy     = sweep_q;

	always_comb begin
		s_old = (fwd_s_valid_q && (fwd_s_addr_q == sum_bin_s2)) ? fwd_s_data_q : s_rdata;
		d_old = (fwd_d_valid_q && (fwd_d_addr_q == diff_bin_s2)) ? fwd_d_data_q : d_rdata;
		s_new = (s_old == '1) ? s_old : s_old + COUNT_BITS'(1);
		d_new = (d_old == '1) ? d_old : d_old + COUNT_BITS'(1);

		if (sweep_q) begin
			wr_en   = 1'b1;
			s_waddr = sweep_addr_q;
			d_waddr = sweep_addr_q;
			s_wdata = '0;
			d_wdata = '0;
		end else begin
			wr_en   = valid_s2 && (op_s2 == sdh_pkg::OP_PAIR);
			s_waddr = sum_bin_s2;
			d_waddr = diff_bin_s2;
			s_wdata = s_new;
			d_wdata = d_new;
		end
	end

	sdh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (sdh_pkg::NBINS)
	) u_sum_bins (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (rd_en),
		.raddr (q_head.sum_bin),
		.rdata (s_rdata)
	);

	sdh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (sdh_pkg::NBINS)
	) u_diff_bins (
		.clk   (clk),
		.we    (wr_en),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (rd_en),
		.raddr (q_head.diff_bin),
		.rdata (d_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q       <= 1'b1;
			sweep_addr_q  <= '0;
			valid_s2      <= 1'b0;
			fwd_s_valid_q <= 1'b0;
			fwd_d_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			fwd_s_valid_q <= wr_en;
			fwd_d_valid_q <= wr_en;
			valid_s2      <= q_pop && (q_head.op != sdh_pkg::OP_CLEAR);

			if (sweep_q) begin
				if (sweep_addr_q == BB'(sdh_pkg::NBINS - 1)) begin
					sweep_q <= 1'b0;
				end
				sweep_addr_q <= sweep_addr_q + BB'(1);
			end else if (q_pop && (q_head.op == sdh_pkg::OP_CLEAR)) begin
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end

			if (valid_s2 && (op_s2 == sdh_pkg::OP_READ)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_s_addr_q <= s_waddr;
		fwd_s_data_q <= s_wdata;
		fwd_d_addr_q <= d_waddr;
		fwd_d_data_q <= d_wdata;
		if (q_pop) begin
			op_s2       <= q_head.op;
			sum_bin_s2  <= q_head.sum_bin;
			diff_bin_s2 <= q_head.diff_bin;
			oor_s2      <= head_oor;
		end
		if (valid_s2 && (op_s2 == sdh_pkg::OP_READ)) begin
			out_sum_q  <= oor_s2 ? '0 : s_old;
			out_diff_q <= oor_s2 ? '0 : d_old;
		end
	end

	assign out_valid  = out_valid_q;
	assign sum_count  = out_sum_q;
	assign diff_count = out_diff_q;

endmodule

[hdl/sum_difference_histogram.sv]
// A read result passes the front end register, the queue, the bin RAM read and the output
// register before it shows on out_valid. Throughput: one pixel per clock while in_stall is low;
// a bin read waits in the queue until the previous result has left the output register.
// A clear sweeps all 511 bins in the histogram engine, one bin of both RAMs per cycle.
// Reset: asynchronous, active low; afterwards the same sweep zeroes the histograms
// while in_stall stays high. Configuration returns to width 1024, distance 1, 0 degrees.
module sum_difference_histogram #(
	parameter int MAX_WIDTH  = sdh_pkg::MAX_WIDTH_DEF,
	parameter int MAX_DIST   = sdh_pkg::MAX_DIST_DEF,
	parameter int COUNT_BITS = sdh_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sdh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [sdh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// Input item channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sdh_pkg::ACT_BITS-1:0]       action,
	input  logic [sdh_pkg::PIXEL_BITS-1:0]     pixel,
	input  logic [sdh_pkg::BIN_BITS-1:0]       bin_index,
	// Result channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [COUNT_BITS-1:0]              sum_count,
	output logic [COUNT_BITS-1:0]              diff_count
);

	// The front end tracks the raster position, keeps the last rows in the line
	// store and turns each pixel into a pair of bin numbers. Clear and read
	// requests pass through it unchanged so that they stay in stream order.
	// The histogram engine behind the queue does the read-modify-write of the
	// two count RAMs, the clearing sweep and the bin reads. The queue lets
	// the front keep taking pixels while the engine waits on a stalled result.

	sdh_pkg::cfg_t     cfg_q;
	sdh_pkg::hist_op_t q_entry;
	sdh_pkg::hist_op_t q_head;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	logic              back_busy;

	// Configuration is always accepted; the user must write it only while the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= sdh_pkg::IMAGE_WIDTH_RESET;
			cfg_q.pair_distance <= sdh_pkg::PAIR_DISTANCE_RESET;
			cfg_q.direction     <= sdh_pkg::DIR_0;
		end else if (cfg_valid && cfg_ready) begin
			case (sdh_pkg::reg_idx_t'(cfg_index))
				sdh_pkg::REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data;
				end
				sdh_pkg::REG_PAIR_DISTANCE: begin
					cfg_q.pair_distance <= cfg_data[sdh_pkg::DIST_BITS-1:0];
				end
				sdh_pkg::REG_DIRECTION: begin
					cfg_q.direction <= sdh_pkg::dir_t'(cfg_data[sdh_pkg::DIR_BITS-1:0]);
				end
				default: begin
					// Writes to an index beyond the register list are dropped.
				end
			endcase
		end
	end

	sdh_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_DIST  (MAX_DIST)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.hold      (back_busy),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.pixel     (pixel),
		.bin_index (bin_index),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	sdh_queue #(
		.DEPTH (sdh_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	sdh_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.busy       (back_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sum_count  (sum_count),
		.diff_count (diff_count)
	);

endmodule

[tb/sdh_checker.sv]
// Watches the configuration, pixel and result channels of the histogram block, keeps its own
// copy of the histograms, line store and position counters, and compares every bin read.
module sdh_checker #(
	parameter int MAX_WIDTH  = sdh_pkg::MAX_WIDTH_DEF,
	parameter int MAX_DIST   = sdh_pkg::MAX_DIST_DEF,
	parameter int COUNT_BITS = sdh_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [sdh_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sdh_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [sdh_pkg::ACT_BITS-1:0]      action,
	input  logic [sdh_pkg::PIXEL_BITS-1:0]    pixel,
	input  logic [sdh_pkg::BIN_BITS-1:0]      bin_index,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [COUNT_BITS-1:0]             sum_count,
	input  logic [COUNT_BITS-1:0]             diff_count,
	output int                                failures,
	output int                                pending
);
	import sdh_pkg::*;

	localparam int ROW_SLOTS = MAX_DIST + 1;
	localparam int ROW_LIMIT = 2047;
	localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

	typedef struct packed {
		logic [COUNT_BITS-1:0] sum_cnt;
		logic [COUNT_BITS-1:0] diff_cnt;
	} bin_counts_t;

	logic [COUNT_BITS-1:0] sum_hist  [NBINS];
	logic [COUNT_BITS-1:0] diff_hist [NBINS];
	logic [PIXEL_BITS-1:0] line_rows [ROW_SLOTS][MAX_WIDTH];
	int unsigned           col_now;
	int unsigned           row_now;
	int unsigned           slot_now;
	logic [IMG_W_BITS-1:0] width_q;
	logic [DIST_BITS-1:0]  dist_q;
	dir_t                  dir_q;
	bin_counts_t           bin_reads [$];
	bin_counts_t           want;

	initial begin
		failures = 0;
		pending  = 0;
	end

	function automatic void clear_histograms();
		for (int i = 0; i < NBINS; i++) begin
			sum_hist[i]  = '0;
			diff_hist[i] = '0;
		end
		col_now  = 0;
		row_now  = 0;
		slot_now = 0;
	endfunction

	function automatic void tally_pair(input int unsigned cur, input int unsigned nb);
		int unsigned s;
		int unsigned df;
		s  = cur + nb;
		df = cur + GRAY_MAX - nb;
		if (s < NBINS && sum_hist[s] != COUNT_FULL)
			sum_hist[s] = sum_hist[s] + 1'b1;
		if (df < NBINS && diff_hist[df] != COUNT_FULL)
			diff_hist[df] = diff_hist[df] + 1'b1;
	endfunction

	// Out-of-range width and distance settings are clamped before use.
	function automatic void absorb_pixel(input logic [PIXEL_BITS-1:0] px);
		int unsigned w;
		int unsigned d;
		int unsigned c;
		int unsigned up;
		w = width_q;
		d = dist_q;
		c = col_now;
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		if (d == 0)
			d = 1;
		if (d > MAX_DIST)
			d = MAX_DIST;
		if (c >= MAX_WIDTH)
			c = MAX_WIDTH - 1;
		line_rows[slot_now][c] = px;
		up = (slot_now + ROW_SLOTS - d) % ROW_SLOTS;
		case (dir_q)
			DIR_0: begin
				if (c >= d && c < w)
					tally_pair(line_rows[slot_now][c - d], px);
			end
			DIR_45: begin
				if (row_now >= d && c + d < w)
					tally_pair(px, line_rows[up][c + d]);
			end
			DIR_90: begin
				if (row_now >= d && c < w)
					tally_pair(px, line_rows[up][c]);
			end
			default: begin
				if (row_now >= d && c >= d && c < w)
					tally_pair(px, line_rows[up][c - d]);
			end
		endcase
		if (c + 1 >= w) begin
			col_now = 0;
			if (row_now < ROW_LIMIT)
				row_now++;
			slot_now = (slot_now + 1) % ROW_SLOTS;
		end else begin
			col_now = c + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_histograms();
			for (int s = 0; s < ROW_SLOTS; s++)
				for (int x = 0; x < MAX_WIDTH; x++)
					line_rows[s][x] = '0;
			width_q = IMAGE_WIDTH_RESET;
			dist_q  = PAIR_DISTANCE_RESET;
			dir_q   = DIR_0;
			bin_reads.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_IMAGE_WIDTH:   width_q = cfg_data[IMG_W_BITS-1:0];
					REG_PAIR_DISTANCE: dist_q  = cfg_data[DIST_BITS-1:0];
					REG_DIRECTION:     dir_q   = dir_t'(cfg_data[DIR_BITS-1:0]);
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (bin_reads.size() == 0) begin
					failures++;
					$error("unexpected result: sum_count %0d, diff_count %0d",
						sum_count, diff_count);
				end else begin
					want = bin_reads.pop_front();
					if (sum_count !== want.sum_cnt) begin
						failures++;
						$error("sum_count mismatch: expected %0d, actual %0d",
							want.sum_cnt, sum_count);
					end
					if (diff_count !== want.diff_cnt) begin
						failures++;
						$error("diff_count mismatch: expected %0d, actual %0d",
							want.diff_cnt, diff_count);
					end
				end
			end

			if (in_valid && !in_stall) begin
				case (action)
					ACT_CLEAR: clear_histograms();
					ACT_PIXEL: absorb_pixel(pixel);
					ACT_READ: begin
						if (bin_index < NBINS)
							bin_reads.push_back({sum_hist[bin_index], diff_hist[bin_index]});
						else
							bin_reads.push_back('0);
					end
					default: ;
				endcase
			end

			pending = bin_reads.size();
		end
	end

endmodule

[tb/tb.sv]
// Stimulus and verdict for the sum and difference histogram block. The checker instance
// beside the block does all prediction and comparison; this module only generates traffic.
module tb;
	import sdh_pkg::*;

	// The random part stops once this many pixel, clear and read transactions have been sent.
	// The pixels and reads in the two wide images at the start of it are not counted, but
	// the clears before them are.
	localparam int RANDOM_ITEMS = 800;
	// A clear keeps the histogram engine busy while it sweeps every bin; this margin covers
	// that sweep and the pipeline registers around it.
	localparam int SETTLE = NBINS + 16;
	localparam int CYCLE_LIMIT = 1000000;
	// Pixels sent into each of the two wide images.
	localparam int WIDE_PIXELS = 48;
	// The fourth action code has no meaning and must be ignored by the block.
	localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [ACT_BITS-1:0]       action;
	logic [PIXEL_BITS-1:0]     pixel;
	logic [BIN_BITS-1:0]       bin_index;
	logic                      out_valid;
	logic                      out_stall;
	logic [COUNT_BITS_DEF-1:0] sum_count;
	logic [COUNT_BITS_DEF-1:0] diff_count;
	int                        failures;
	int                        pending;

	int unsigned cycle_count = 0;
	int          burst_left = 0;
	bit          smooth = 1'b0;
	int          stall_hold = 0;
	int          stall_mode = 0;

	sum_difference_histogram dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.pixel      (pixel),
		.bin_index  (bin_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sum_count  (sum_count),
		.diff_count (diff_count)
	);

	sdh_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.pixel      (pixel),
		.bin_index  (bin_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sum_count  (sum_count),
		.diff_count (diff_count),
		.failures   (failures),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs on a handshake or drops a result.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The result side stalls on its own schedule. Every so often it picks a new mode: no
	// stalls at all, a coin flip each cycle, mostly stalled, or long runs that flip rarely.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_hold <= $urandom_range(32, 200);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
		endcase
	end

	// Presents one transaction and returns in the time step where it was taken. The sender
	// works in bursts; between bursts it may drop valid for a random gap unless the current
	// image is being streamed without gaps.
	task automatic put_item(input logic [ACT_BITS-1:0] act, input logic [PIXEL_BITS-1:0] px,
			input logic [BIN_BITS-1:0] bin);
		int gap;
		if (burst_left == 0) begin
			gap = smooth ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid  <= 1'b1;
		action    <= act;
		pixel     <= px;
		bin_index <= bin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
	endtask

	// Drops valid and waits until every read has come back, then lets the pipeline settle
	// so that clears and pixels without a result have also left the block.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes never lower and raise it in one step;
	// the caller lowers it after the last write.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_setup(input logic [IMG_W_BITS-1:0] w, input logic [DIST_BITS-1:0] d,
			input dir_t dir);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_PAIR_DISTANCE, CFG_DATA_BITS'(d));
		write_reg(REG_DIRECTION, CFG_DATA_BITS'(dir));
		cfg_valid <= 1'b0;
	endtask

	// Unless wide is set, pixels come from a narrow band above base, so half of the reads aim at
	// the sum bins around twice the base or at the difference bins around zero difference.
	function automatic logic [BIN_BITS-1:0] pick_bin(input int base);
		case ($urandom_range(0, 3))
			0: return BIN_BITS'($urandom_range(0, NBINS));
			1: return BIN_BITS'(2 * base + $urandom_range(0, 14));
			2: return BIN_BITS'(GRAY_MAX - 7 + $urandom_range(0, 14));
			default: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return BIN_BITS'(NBINS - 1);
					default: return BIN_BITS'(NBINS);
				endcase
			end
		endcase
	endfunction

	initial begin
		int                    phase;
		int                    counted;
		int                    w_eff;
		int                    rows;
		int                    npix;
		int                    shrink_at;
		int                    base;
		int                    roll;
		bit                    wide;
		bit                    big;
		logic [IMG_W_BITS-1:0] w_set;
		logic [DIST_BITS-1:0]  d_set;
		dir_t                  dir_set;
		logic [PIXEL_BITS-1:0] px;

		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		action    = ACT_CLEAR;
		pixel     = '0;
		bin_index = '0;
		out_stall = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A two pixel wide image with horizontal pairs at distance one
		// produces the pairs (0,255), (255,0), (255,255) and (0,0), which hit both ends of
		// the sum and difference ranges. A read right after reset sees empty bins, and
		// the read of bin 511 lies beyond the histograms and must return zero counts.
		load_setup(11'd2, 2'd1, DIR_0);
		put_item(ACT_READ, '0, BIN_BITS'(GRAY_MAX));
		put_item(ACT_CLEAR, '0, '0);
		put_item(ACT_PIXEL, 8'd0, '0);
		put_item(ACT_PIXEL, 8'd255, '0);
		put_item(ACT_PIXEL, 8'd255, '0);
		put_item(ACT_PIXEL, 8'd0, '0);
		put_item(ACT_UNUSED, 8'd255, '1);
		put_item(ACT_PIXEL, 8'd255, '0);
		put_item(ACT_PIXEL, 8'd255, '0);
		put_item(ACT_PIXEL, 8'd0, '0);
		put_item(ACT_PIXEL, 8'd0, '0);
		put_item(ACT_READ, '0, '0);
		put_item(ACT_READ, '0, BIN_BITS'(GRAY_MAX));
		put_item(ACT_READ, '0, BIN_BITS'(NBINS - 1));
		put_item(ACT_READ, '0, BIN_BITS'(NBINS));

		// Random part: one image per phase, each behind a fresh configuration and a
		// clear. The first phase sets a width above the line store (it acts as full
		// width) with distance zero, the second the exact full width at the largest
		// distance; both send only the start of the first row. Later phases use small
		// widths, including zero and one.
		phase   = 0;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			big = (phase < 2);
			if (phase == 0) begin
				w_set = 11'd2047;
				d_set = 2'd0;
				rows  = 2;
			end else if (phase == 1) begin
				w_set = 11'd1024;
				d_set = 2'd2;
				rows  = 3;
			end else begin
				case ($urandom_range(0, 9))
					0: w_set = 11'd0;
					1: w_set = 11'd1;
					2: w_set = 11'd2;
					3: w_set = IMG_W_BITS'($urandom_range(33, 64));
					default: w_set = IMG_W_BITS'($urandom_range(2, 16));
				endcase
				d_set = DIST_BITS'($urandom_range(0, 3));
				rows  = (w_set <= 2) ? $urandom_range(2, 16) : $urandom_range(1, 6);
			end
			dir_set = dir_t'($urandom_range(0, 3));
			w_eff   = (w_set == 0) ? 1 : (w_set > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_set;
			npix    = big ? WIDE_PIXELS : rows * w_eff;
			base    = $urandom_range(0, GRAY_MAX - 7);
			wide    = ($urandom_range(0, 3) == 0);
			smooth  = ($urandom_range(0, 3) == 0);
			// Now and then the width shrinks in the middle of the image, together with a
			// new distance and direction. A shrink never exposes unwritten line store
			// entries, since the rows above are at least as wide.
			shrink_at = (!big && w_eff >= 3 && $urandom_range(0, 3) == 0)
				? $urandom_range(1, npix - 1) : -1;

			quiesce();
			load_setup(w_set, d_set, dir_set);
			put_item(ACT_CLEAR, '0, '0);
			counted++;

			for (int k = 0; k < npix; k++) begin
				if (k == shrink_at) begin
					quiesce();
					write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'($urandom_range(1, w_eff - 1)));
					write_reg(REG_PAIR_DISTANCE, CFG_DATA_BITS'($urandom_range(0, 3)));
					write_reg(REG_DIRECTION, CFG_DATA_BITS'($urandom_range(0, 3)));
					cfg_valid <= 1'b0;
				end
				// Reads land in the middle of the stream, with a little noise: the unused
				// action code and, in small images, a stray clear that restarts the image.
				roll = $urandom_range(0, 99);
				if (roll < 18) begin
					put_item(ACT_READ, PIXEL_BITS'($urandom), pick_bin(base));
					counted += big ? 0 : 1;
				end else if (roll < 21) begin
					put_item(ACT_UNUSED, PIXEL_BITS'($urandom), BIN_BITS'($urandom));
				end else if (roll < 22 && !big) begin
					put_item(ACT_CLEAR, PIXEL_BITS'($urandom), BIN_BITS'($urandom));
					counted++;
				end
				px = wide ? PIXEL_BITS'($urandom_range(0, 255))
					: PIXEL_BITS'(base + $urandom_range(0, 7));
				put_item(ACT_PIXEL, px, BIN_BITS'($urandom));
				counted += big ? 0 : 1;
			end

			repeat ($urandom_range(3, 10)) begin
				put_item(ACT_READ, PIXEL_BITS'($urandom), pick_bin(base));
				counted += big ? 0 : 1;
			end
			phase++;
		end

		// Drain every outstanding read before giving the verdict.
		quiesce();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
